@@ rtl/slbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbc_pkg
// Shared types, codes and lookup functions of the status LED blink-code block.
// ----------------------------------------------------------------------------
package slbc_pkg;

	// width of the elapsed and pulse counters
	localparam int TIMER_WIDTH = 16;
	// width of the timing registers
	localparam int CFG_MS_WIDTH = 16;
	localparam int CMP_WIDTH = (TIMER_WIDTH > CFG_MS_WIDTH) ? TIMER_WIDTH : CFG_MS_WIDTH;
	localparam int STEP_IDX_WIDTH = 5;

	// item kinds
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_STATE = 2'd1;
	localparam logic [1:0] FUNC_PULSE = 2'd2;

	// led modes
	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_ON  = 2'd1;
	localparam logic [1:0] MODE_1HZ = 2'd2;
	localparam logic [1:0] MODE_4HZ = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_BLINK_STEP_MS = 2'd0;
	localparam logic [1:0] REG_PULSE_MS      = 2'd1;
	localparam logic [1:0] REG_PAUSE_STEPS   = 2'd2;

	// reset values of the configuration registers
	localparam logic [CFG_MS_WIDTH-1:0] BLINK_STEP_MS_RST = 16'd150;
	localparam logic [CFG_MS_WIDTH-1:0] PULSE_MS_RST      = 16'd250;
	localparam logic [3:0]              PAUSE_STEPS_RST   = 4'd6;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] new_state;
	} slbc_in_t;

	typedef struct packed {
		logic       led_write;
		logic [1:0] led_mode;
	} slbc_out_t;

	typedef struct packed {
		logic [CFG_MS_WIDTH-1:0] blink_step_ms;
		logic [CFG_MS_WIDTH-1:0] pulse_ms;
		logic [3:0]              pause_steps;
	} slbc_cfg_t;

	function automatic logic [1:0] base_mode(input logic [3:0] st);
		logic [1:0] m;
		unique case (st)
			4'd0: m = MODE_ON;
			4'd1: m = MODE_4HZ;
			4'd2: m = MODE_4HZ;
			4'd3: m = MODE_1HZ;
			4'd4: m = MODE_ON;
			default: m = MODE_OFF;
		endcase
		return m;
	endfunction

	// number of blinks in the pattern, zero for states without a pattern
	function automatic logic [3:0] blink_count(input logic [3:0] st);
		logic [3:0] n;
		if (st >= 4'd5 && st <= 4'd11) begin
			n = st - 4'd3;
		end else begin
			n = 4'd0;
		end
		return n;
	endfunction

endpackage

@@ rtl/slbc_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbc_engine
// Holds the indicator state and computes one result per fired item.
// ----------------------------------------------------------------------------
module slbc_engine
	import slbc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  slbc_in_t  item,
	input  slbc_cfg_t cfg,
	output slbc_out_t result
);

	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

	logic [3:0]                current_status_q, current_status_n;
	logic                      status_valid_q, status_valid_n;
	logic [STEP_IDX_WIDTH-1:0] step_idx_q, step_idx_n;
	logic [TIMER_WIDTH-1:0]    since_q, since_n;
	logic                      pulse_active_q, pulse_active_n;
	logic [TIMER_WIDTH-1:0]    pulse_rem_q, pulse_rem_n;

	logic [TIMER_WIDTH-1:0]    since_inc;
	logic [TIMER_WIDTH-1:0]    rem_dec;
	logic [TIMER_WIDTH-1:0]    pulse_load;
	logic [3:0]                n_blinks;
	logic [STEP_IDX_WIDTH-1:0] twice_n;
	logic [STEP_IDX_WIDTH-1:0] seq_len;
	logic [STEP_IDX_WIDTH-1:0] idx_inc;
	logic                      held;
	logic                      step_due;

	always_comb begin
		since_inc = (since_q == TIMER_MAX) ? since_q : since_q + 1'b1;
		rem_dec   = (pulse_rem_q != '0) ? pulse_rem_q - 1'b1 : pulse_rem_q;
		// clamp the pulse length to the counter range
		pulse_load = (CMP_WIDTH'(cfg.pulse_ms) > CMP_WIDTH'(TIMER_MAX)) ?
			TIMER_MAX : TIMER_WIDTH'(cfg.pulse_ms);
		n_blinks = blink_count(current_status_q);
		twice_n  = STEP_IDX_WIDTH'({n_blinks, 1'b0});
		seq_len  = twice_n + STEP_IDX_WIDTH'(cfg.pause_steps);
		idx_inc  = step_idx_q + 1'b1;
		step_due = CMP_WIDTH'(since_inc) >= CMP_WIDTH'(cfg.blink_step_ms);

		current_status_n = current_status_q;
		status_valid_n   = status_valid_q;
		step_idx_n       = step_idx_q;
		since_n          = since_q;
		pulse_active_n   = pulse_active_q;
		pulse_rem_n      = pulse_rem_q;
		held             = 1'b0;
		result.led_write = 1'b0;
		result.led_mode  = MODE_OFF;

		unique case (item.func)
			FUNC_STATE: begin
				if (!(status_valid_q && current_status_q == item.new_state)) begin
					current_status_n = item.new_state;
					status_valid_n   = 1'b1;
					step_idx_n       = '0;
					pulse_active_n   = 1'b0;
					result.led_write = 1'b1;
					result.led_mode  = base_mode(item.new_state);
				end
			end
			FUNC_PULSE: begin
				pulse_active_n   = 1'b1;
				pulse_rem_n      = pulse_load;
				result.led_write = 1'b1;
				result.led_mode  = MODE_ON;
			end
			FUNC_TICK: begin
				since_n     = since_inc;
				pulse_rem_n = rem_dec;
				if (pulse_active_q) begin
					if (rem_dec != '0) begin
						held = 1'b1;
					end else begin
						pulse_active_n   = 1'b0;
						result.led_write = 1'b1;
						result.led_mode  = base_mode(current_status_q);
					end
				end
				// a blink step overrides the mode written by the pulse end
				if (!held && n_blinks != 4'd0 && step_due) begin
					since_n    = '0;
					step_idx_n = idx_inc;
					priority if (idx_inc <= twice_n) begin
						result.led_write = 1'b1;
						result.led_mode  = idx_inc[0] ? MODE_ON : MODE_OFF;
					end else if (idx_inc >= seq_len) begin
						step_idx_n = '0;
					end else begin
						result.led_write = 1'b1;
						result.led_mode  = MODE_OFF;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_status_q <= '0;
			status_valid_q   <= 1'b0;
			step_idx_q       <= '0;
			since_q          <= '0;
			pulse_active_q   <= 1'b0;
			pulse_rem_q      <= '0;
		end else if (fire) begin
			current_status_q <= current_status_n;
			status_valid_q   <= status_valid_n;
			step_idx_q       <= step_idx_n;
			since_q          <= since_n;
			pulse_active_q   <= pulse_active_n;
			pulse_rem_q      <= pulse_rem_n;
		end
	end

endmodule

@@ rtl/status_led_blink_code.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_blink_code
// Status LED mode controller driven by state, pulse and millisecond tick beats.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data) takes one beat per item: a
// millisecond tick, a state change or a success pulse. Every item yields
// exactly one result beat on the output channel (out_valid / out_stall /
// out_data) carrying led_write and the mode written.
// The beat is held in the input register, then the state update writes the
// result register once the output register is free or being drained.
// Throughput is one item per clock while the output is not stalled.
// When the receiver stalls, the output register holds its beat; the input
// register still fills, and in_stall rises once both registers are full.
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
// always ready; writes are expected only while the block is idle.
// Reset clears the indicator state, both pipeline valids and loads the
// timing registers with 150 ms step, 250 ms pulse and 6 pause steps.
// ----------------------------------------------------------------------------
module status_led_blink_code
	import slbc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  slbc_in_t                in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output slbc_out_t               out_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_MS_WIDTH-1:0] cfg_data
);

	slbc_cfg_t cfg_q;
	slbc_in_t  item_s1;
	logic      valid_s1;
	slbc_out_t result;
	slbc_out_t out_s2;
	logic      valid_s2;
	logic      adv_out;
	logic      fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_step_ms <= BLINK_STEP_MS_RST;
			cfg_q.pulse_ms      <= PULSE_MS_RST;
			cfg_q.pause_steps   <= PAUSE_STEPS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLINK_STEP_MS: cfg_q.blink_step_ms <= cfg_data;
				REG_PULSE_MS:      cfg_q.pulse_ms      <= cfg_data;
				REG_PAUSE_STEPS:   cfg_q.pause_steps   <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// output register is free or being drained this cycle
	assign adv_out  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv_out;
	assign in_stall = valid_s1 && !adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv_out) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			out_s2 <= result;
		end
	end

	slbc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

endmodule

@@ dv/led_mode_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_mode_checker
// Watches the item, result and register channels of status_led_blink_code,
// keeps a shadow of the indicator state and timing registers, works out the
// LED result of every accepted item and compares it with the block's output.
// ----------------------------------------------------------------------------
module led_mode_checker
	import slbc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  slbc_in_t                in_data,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  slbc_out_t               out_data,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_MS_WIDTH-1:0] cfg_data,
	output int                      mismatches,
	output int                      leds_pending,
	output int                      leds_written
);

	localparam int REPORT_CAP = 200;

	// shadow of the indicator state
	logic [3:0]             cur_state;
	logic                   state_known;
	logic [4:0]             step_idx;
	logic [TIMER_WIDTH-1:0] since_step;
	logic                   pulse_on;
	logic [TIMER_WIDTH-1:0] pulse_left;

	// shadow of the timing registers
	logic [CFG_MS_WIDTH-1:0] step_ms;
	logic [CFG_MS_WIDTH-1:0] pulse_len;
	logic [3:0]              pause_len;

	slbc_out_t pending_leds[$];
	int errs;
	int writes;

	function automatic logic [1:0] steady_mode(input logic [3:0] st);
		logic [1:0] m;
		case (st)
			4'd0, 4'd4: m = MODE_ON;
			4'd1, 4'd2: m = MODE_4HZ;
			4'd3: m = MODE_1HZ;
			default: m = MODE_OFF;
		endcase
		return m;
	endfunction

	function automatic int pattern_blinks(input logic [3:0] st);
		int n;
		n = 0;
		if (st >= 4'd5 && st <= 4'd11) begin
			n = int'(st) - 3;
		end
		return n;
	endfunction

	// advances the shadow state by one item and returns the LED result it causes
	function automatic slbc_out_t led_after_item(input slbc_in_t item);
		slbc_out_t r;
		bit hold;
		int n;
		int seq;
		r = '0;
		hold = 1'b0;
		case (item.func)
			FUNC_STATE: begin
				if (!(state_known && cur_state == item.new_state)) begin
					cur_state = item.new_state;
					state_known = 1'b1;
					step_idx = '0;
					pulse_on = 1'b0;
					r.led_write = 1'b1;
					r.led_mode = steady_mode(item.new_state);
				end
			end
			FUNC_PULSE: begin
				pulse_on = 1'b1;
				pulse_left = pulse_len;
				r.led_write = 1'b1;
				r.led_mode = MODE_ON;
			end
			FUNC_TICK: begin
				if (since_step != '1) begin
					since_step = since_step + 1'b1;
				end
				if (pulse_left != '0) begin
					pulse_left = pulse_left - 1'b1;
				end
				if (pulse_on) begin
					if (pulse_left != '0) begin
						hold = 1'b1;
					end else begin
						pulse_on = 1'b0;
						r.led_write = 1'b1;
						r.led_mode = steady_mode(cur_state);
					end
				end
				n = pattern_blinks(cur_state);
				// a blink step overrides the mode written when a pulse ends
				if (!hold && n != 0 && since_step >= step_ms) begin
					seq = 2 * n + int'(pause_len);
					since_step = '0;
					step_idx = step_idx + 5'd1;
					if (step_idx <= 2 * n) begin
						r.led_write = 1'b1;
						r.led_mode = step_idx[0] ? MODE_ON : MODE_OFF;
					end else if (step_idx >= seq) begin
						step_idx = '0;
					end else begin
						r.led_write = 1'b1;
						r.led_mode = MODE_OFF;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slbc_out_t want;
		if (!arst_n) begin
			cur_state = 4'd0;
			state_known = 1'b0;
			step_idx = '0;
			since_step = '0;
			pulse_on = 1'b0;
			pulse_left = '0;
			step_ms = BLINK_STEP_MS_RST;
			pulse_len = PULSE_MS_RST;
			pause_len = PAUSE_STEPS_RST;
			pending_leds.delete();
			errs = 0;
			writes = 0;
			mismatches <= 0;
			leds_pending <= 0;
			leds_written <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BLINK_STEP_MS: step_ms = cfg_data;
					REG_PULSE_MS: pulse_len = cfg_data;
					REG_PAUSE_STEPS: pause_len = cfg_data[3:0];
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				pending_leds.push_back(led_after_item(in_data));
			end
			if (out_valid && !out_stall) begin
				if (pending_leds.size() == 0) begin
					errs++;
					if (errs <= REPORT_CAP) begin
						$display("%0t: unexpected result beat: expected none, got write %0b mode %0d",
							$time, out_data.led_write, out_data.led_mode);
					end
				end else begin
					want = pending_leds.pop_front();
					if (out_data.led_write !== want.led_write) begin
						errs++;
						if (errs <= REPORT_CAP) begin
							$display("%0t: led_write mismatch: expected %0b, got %0b",
								$time, want.led_write, out_data.led_write);
						end
					end
					if (out_data.led_mode !== want.led_mode) begin
						errs++;
						if (errs <= REPORT_CAP) begin
							$display("%0t: led_mode mismatch: expected %0d, got %0d",
								$time, want.led_mode, out_data.led_mode);
						end
					end
					if (want.led_write) begin
						writes++;
					end
				end
			end
			mismatches <= errs;
			leds_pending <= pending_leds.size();
			leds_written <= writes;
		end
	end

endmodule

@@ dv/tb_status_led_blink_code.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_status_led_blink_code
// Drives tick, state, pulse and unused-code beats into status_led_blink_code under a
// series of timing register settings, with random gaps on both channels;
// led_mode_checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_status_led_blink_code;
	import slbc_pkg::*;

	localparam int          TIMEOUT_CYCLES = 10_000_000;
	localparam int          HOLD_TICKS     = 20;
	localparam logic [1:0]  FUNC_UNUSED    = 2'd3;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	slbc_in_t                in_data = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	slbc_out_t               out_data;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [1:0]              cfg_index = REG_BLINK_STEP_MS;
	logic [CFG_MS_WIDTH-1:0] cfg_data = '0;

	int mismatches;
	int leds_pending;
	int leds_written;
	int cycles = 0;
	int items_sent = 0;
	int settings_used = 0;
	bit quiet = 1'b0;

	status_led_blink_code DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	led_mode_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.leds_pending(leds_pending),
		.leds_written(leds_written)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= TIMEOUT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: free runs then stall bursts, mostly short
	initial begin
		int n;
		int r;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 70) n = $urandom_range(1, 4);
			else if (r < 92) n = $urandom_range(5, 20);
			else n = $urandom_range(50, 200);
			out_stall <= 1'b0;
			repeat (n) @(posedge clk);
			if (!quiet) begin
				r = $urandom_range(0, 99);
				if (r < 85) n = $urandom_range(1, 3);
				else if (r < 97) n = $urandom_range(4, 10);
				else n = $urandom_range(20, 40);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		else if (r < 90) return $urandom_range(1, 3);
		else if (r < 97) return $urandom_range(4, 10);
		else return $urandom_range(20, 80);
	endfunction

	task automatic send(input logic [1:0] f, input logic [3:0] st);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= slbc_in_t'({f, st});
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (f != FUNC_UNUSED) items_sent++;
	endtask

	// drop valid and let every outstanding result beat come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (leds_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_timing(input logic [15:0] step_ms, input logic [15:0] pulse_len,
			input logic [3:0] pause_len);
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			case (k)
				0: begin
					cfg_index <= REG_BLINK_STEP_MS;
					cfg_data <= step_ms;
				end
				1: begin
					cfg_index <= REG_PULSE_MS;
					cfg_data <= pulse_len;
				end
				default: begin
					cfg_index <= REG_PAUSE_STEPS;
					cfg_data <= {12'd0, pause_len};
				end
			endcase
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// mostly a state change followed by a run of ticks, sometimes pure noise
	task automatic random_phase(input logic [15:0] step_ms, input logic [15:0] pulse_len,
			input logic [3:0] pause_len, input int count);
		int sent;
		int kind;
		int len;
		int r;
		logic [3:0] st;
		load_timing(step_ms, pulse_len, pause_len);
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				len = $urandom_range(3, 12);
				repeat (len) begin
					send(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
					sent++;
				end
			end else begin
				if ($urandom_range(0, 99) < 70) st = 4'($urandom_range(5, 11));
				else st = 4'($urandom_range(0, 15));
				if (kind < 35) begin
					send(FUNC_PULSE, 4'($urandom_range(0, 15)));
					sent++;
				end
				send(FUNC_STATE, st);
				sent++;
				len = $urandom_range(5, 60);
				repeat (len) begin
					r = $urandom_range(0, 99);
					if (r < 5) send(FUNC_PULSE, 4'($urandom_range(0, 15)));
					else if (r < 7) send(FUNC_STATE, st);
					else if (r < 9) send(FUNC_UNUSED, 4'($urandom_range(0, 15)));
					else send(FUNC_TICK, 4'($urandom_range(0, 15)));
					sent++;
				end
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset timing
		send(FUNC_TICK, 4'd0);
		send(FUNC_UNUSED, 4'd15);
		// first state beat writes even though it matches the reset state
		send(FUNC_STATE, 4'd0);
		send(FUNC_STATE, 4'd0);
		for (int s = 1; s < 16; s++) begin
			send(FUNC_STATE, 4'(s));
		end
		send(FUNC_PULSE, 4'd15);
		send(FUNC_TICK, 4'd15);
		send(FUNC_UNUSED, 4'd0);
		send(FUNC_PULSE, 4'd0);
		wait_idle();

		random_phase(16'd1, 16'd1, 4'd1, 130);
		// zero registers: step every tick, pulse ends at the next tick
		random_phase(16'd0, 16'd0, 4'd0, 130);

		// maximal step and pulse in a dark state, then a state change cuts the pulse
		load_timing(16'hFFFF, 16'hFFFF, 4'd15);
		quiet = 1'b1;
		send(FUNC_STATE, 4'd12);
		send(FUNC_PULSE, 4'd0);
		repeat (HOLD_TICKS) send(FUNC_TICK, 4'($urandom_range(0, 15)));
		send(FUNC_STATE, 4'd11);
		repeat (4) send(FUNC_TICK, 4'd0);
		wait_idle();
		quiet = 1'b0;

		random_phase(16'd2, 16'd5, 4'd15, 130);
		// shorter pause after a long one leaves the step index past the sequence
		random_phase(16'd3, 16'd2, 4'd1, 120);
		for (int p = 0; p < 4; p++) begin
			quiet = (p == 2);
			random_phase(16'($urandom_range(1, 4)), 16'($urandom_range(0, 10)),
				4'($urandom_range(0, 15)), 125);
		end
		quiet = 1'b0;

		wait_idle();
		repeat (10) @(posedge clk);
		$display("tb: %0d items (with a %0d-tick hold) under %0d timing settings",
			items_sent, HOLD_TICKS, settings_used);
		$display("tb: %0d LED writes checked, %0d mismatches, %0d results missing",
			leds_written, mismatches, leds_pending);
		if (mismatches == 0 && leds_pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
